[rtl/prqs_pkg.sv]
// Shared opcodes, priority levels and controller/datapath interface types.
package prqs_pkg;

    localparam logic [2:0] OP_ENQUEUE   = 3'd0;
    localparam logic [2:0] OP_DEQ_HIGH  = 3'd1;
    localparam logic [2:0] OP_DEQ_AT    = 3'd2;
    localparam logic [2:0] OP_PEEK_HIGH = 3'd3;
    localparam logic [2:0] OP_PEEK_AT   = 3'd4;

    localparam logic [1:0] LVL_IDLE   = 2'd0;
    localparam logic [1:0] LVL_LOW    = 2'd1;
    localparam logic [1:0] LVL_NORMAL = 2'd2;
    localparam logic [1:0] LVL_HIGH   = 2'd3;

    localparam int NUM_QUEUES = 3;

    typedef struct packed {
        logic capture;
        logic exec;
        logic respond;
    } prqs_cmd_t;

    typedef struct packed {
        logic out_full;
    } prqs_status_t;

endpackage

[rtl/priority_ready_queue_scheduler_core.sv]
// Strict-priority thread ready-queue scheduler: three FIFO levels plus an idle slot.
// A result reaches the output register through the capture, execute and respond steps;
// respond waits while the output register holds a stalled result. A new request is taken
// only after the previous one has passed capture, execute and respond around the queue memory's registered read port.
// The next request is taken while a result still waits in the output register.
// Reset (asynchronous, active low) empties all queues and clears the idle slot at once.
module priority_ready_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic [7:0] thread_id,
    input  logic [1:0] priority_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       found,
    output logic [7:0] result_id,
    output logic [1:0] result_level,
    output logic       overflow
);

    prqs_pkg::prqs_cmd_t    cmd;
    prqs_pkg::prqs_status_t status;

    prqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    prqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .result_id    (result_id),
        .result_level (result_level),
        .overflow     (overflow)
    );

endmodule

[rtl/prqs_ctrl.sv]
// Controller state machine that sequences capture, execute and respond steps.
module prqs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  prqs_pkg::prqs_status_t status,
    output prqs_pkg::prqs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.respond = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // Hold the finished request until the output register can take it.
                if (!status.out_full)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/prqs_datapath.sv]
// Queue storage, pointers, idle slot, priority select and output register.
module prqs_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  prqs_pkg::prqs_cmd_t    cmd,
    output prqs_pkg::prqs_status_t status,
    input  logic [2:0]             opcode,
    input  logic [7:0]             thread_id,
    input  logic [1:0]             priority_req,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [7:0]             result_id,
    output logic [1:0]             result_level,
    output logic                   overflow
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int NQ    = prqs_pkg::NUM_QUEUES;

    // Captured request.
    logic [2:0]         op_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [1:0]         prio_reg;

    // Queue state.
    logic [ID_BITS-1:0] q_mem [0:NQ-1][0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0]   head_reg [0:NQ-1];
    logic [CNT_W-1:0]   cnt_reg  [0:NQ-1];
    logic [ID_BITS-1:0] idle_id_reg;
    logic               idle_valid_reg;

    // Results of the execute step.
    logic               hit_reg;
    logic               pop_reg;
    logic               ovf_reg;
    logic [1:0]         level_reg;
    logic [1:0]         q_reg;
    logic [PTR_W-1:0]   head_inc_reg;
    logic [CNT_W-1:0]   cnt_dec_reg;
    logic [ID_BITS-1:0] rd_data_reg;

    // Output register.
    logic               out_valid_reg;
    logic               found_reg;
    logic [7:0]         result_id_reg;
    logic [1:0]         result_level_reg;
    logic               overflow_reg;

    // Execute-step decode.
    logic               sel_hit;
    logic               sel_pop;
    logic               sel_enq;
    logic [1:0]         sel_level;
    logic [1:0]         sel_q;
    logic [CNT_W-1:0]   sel_cnt;
    logic [PTR_W-1:0]   sel_head;
    logic [PTR_W-1:0]   sel_head_inc;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   sel_tail;
    logic               sel_full;
    logic               enq_idle;
    logic               enq_write;
    logic               enq_drop;
    logic [ID_BITS-1:0] resp_id;

    always_comb
    begin
        sel_hit   = 1'b0;
        sel_pop   = 1'b0;
        sel_enq   = 1'b0;
        sel_level = prqs_pkg::LVL_IDLE;
        unique case (op_reg)
            prqs_pkg::OP_ENQUEUE:
            begin
                sel_enq   = 1'b1;
                sel_level = prio_reg;
            end
            prqs_pkg::OP_DEQ_HIGH, prqs_pkg::OP_PEEK_HIGH:
            begin
                sel_pop = (op_reg == prqs_pkg::OP_DEQ_HIGH);
                priority if (cnt_reg[2] != '0)
                begin
                    sel_hit   = 1'b1;
                    sel_level = prqs_pkg::LVL_HIGH;
                end
                else if (cnt_reg[1] != '0)
                begin
                    sel_hit   = 1'b1;
                    sel_level = prqs_pkg::LVL_NORMAL;
                end
                else if (cnt_reg[0] != '0)
                begin
                    sel_hit   = 1'b1;
                    sel_level = prqs_pkg::LVL_LOW;
                end
                else
                begin
                    sel_hit   = idle_valid_reg;
                    sel_level = prqs_pkg::LVL_IDLE;
                end
            end
            prqs_pkg::OP_DEQ_AT, prqs_pkg::OP_PEEK_AT:
            begin
                sel_pop   = (op_reg == prqs_pkg::OP_DEQ_AT);
                sel_level = prio_reg;
                unique case (prio_reg)
                    prqs_pkg::LVL_IDLE:   sel_hit = idle_valid_reg;
                    prqs_pkg::LVL_LOW:    sel_hit = (cnt_reg[0] != '0);
                    prqs_pkg::LVL_NORMAL: sel_hit = (cnt_reg[1] != '0);
                    prqs_pkg::LVL_HIGH:   sel_hit = (cnt_reg[2] != '0);
                    default:              sel_hit = 1'b0;
                endcase
                // A miss reports level zero.
                if (!sel_hit)
                begin
                    sel_level = prqs_pkg::LVL_IDLE;
                end
            end
            default:
            begin
                sel_level = prqs_pkg::LVL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (sel_level)
            prqs_pkg::LVL_HIGH:   sel_q = 2'd2;
            prqs_pkg::LVL_NORMAL: sel_q = 2'd1;
            default:              sel_q = 2'd0;
        endcase
    end

    always_comb
    begin
        sel_cnt  = '0;
        sel_head = '0;
        for (int i = 0; i < NQ; i++)
        begin
            if (sel_q == 2'(i))
            begin
                sel_cnt  = cnt_reg[i];
                sel_head = head_reg[i];
            end
        end
    end

    assign sel_head_inc = (sel_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + PTR_W'(1);
    assign tail_sum     = SUM_W'(sel_head) + SUM_W'(sel_cnt);
    assign sel_tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                          ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                          : PTR_W'(tail_sum);
    assign sel_full     = (sel_cnt >= CNT_W'(QUEUE_DEPTH));

    assign enq_idle  = cmd.exec && sel_enq && (sel_level == prqs_pkg::LVL_IDLE);
    assign enq_write = cmd.exec && sel_enq && (sel_level != prqs_pkg::LVL_IDLE) && !sel_full;
    assign enq_drop  = sel_enq && (sel_level != prqs_pkg::LVL_IDLE) && sel_full;

    // Queue memory: one write port for enqueue, one registered read port at the head.
    always_ff @(posedge clk)
    begin
        if (enq_write)
        begin
            q_mem[sel_q][sel_tail] <= id_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= q_mem[sel_q][sel_head];
        end
    end

    // Request capture and execute-step results carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            id_reg   <= ID_BITS'(thread_id);
            prio_reg <= priority_req;
        end
        if (cmd.exec)
        begin
            hit_reg      <= sel_hit;
            pop_reg      <= sel_pop;
            ovf_reg      <= enq_drop;
            level_reg    <= sel_level;
            q_reg        <= sel_q;
            head_inc_reg <= sel_head_inc;
            cnt_dec_reg  <= sel_cnt - CNT_W'(1);
        end
    end

    assign resp_id = (level_reg == prqs_pkg::LVL_IDLE) ? idle_id_reg : rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            idle_id_reg    <= '0;
            idle_valid_reg <= 1'b0;
        end
        else
        begin
            if (enq_idle)
            begin
                idle_id_reg    <= id_reg;
                idle_valid_reg <= 1'b1;
            end
            if (enq_write)
            begin
                for (int i = 0; i < NQ; i++)
                begin
                    if (sel_q == 2'(i))
                    begin
                        cnt_reg[i] <= sel_cnt + CNT_W'(1);
                    end
                end
            end
            if (cmd.respond && pop_reg && hit_reg)
            begin
                if (level_reg == prqs_pkg::LVL_IDLE)
                begin
                    idle_valid_reg <= 1'b0;
                end
                else
                begin
                    for (int i = 0; i < NQ; i++)
                    begin
                        if (q_reg == 2'(i))
                        begin
                            head_reg[i] <= head_inc_reg;
                            cnt_reg[i]  <= cnt_dec_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.respond)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            found_reg        <= hit_reg;
            result_id_reg    <= hit_reg ? 8'(resp_id) : 8'd0;
            result_level_reg <= hit_reg ? level_reg : prqs_pkg::LVL_IDLE;
            overflow_reg     <= ovf_reg;
        end
    end

    assign status.out_full = out_valid_reg && out_stall;

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign result_id    = result_id_reg;
    assign result_level = result_level_reg;
    assign overflow     = overflow_reg;

endmodule
